// ----- rtl/core/tcme_pkg.sv -----
// ----------------------------------------------------------------------------
// tcme_pkg
// Shared types and constants of the tile collision mask engine.
// ----------------------------------------------------------------------------
package tcme_pkg;

  localparam int unsigned DEF_MAX_COLUMNS = 128;
  localparam int unsigned DEF_MAX_ROWS    = 128;

  // Tile index fields in a command; covers grids up to 1024 per side.
  localparam int unsigned COORD_W     = 10;
  localparam int unsigned QUEUE_DEPTH = 2;

  // |p - origin| needs 26 bits; signed tile index needs one more.
  localparam int unsigned DIV_NUM_W = 26;
  localparam int unsigned DIV_DEN_W = 16;
  localparam int unsigned TILE_W    = 27;

  localparam logic [1:0] CODE_EMPTY = 2'd0;
  localparam logic [1:0] CODE_HARD  = 2'd2;

  localparam logic [2:0] CFG_ORIGIN_X    = 3'd0;
  localparam logic [2:0] CFG_ORIGIN_Y    = 3'd1;
  localparam logic [2:0] CFG_TILE_WIDTH  = 3'd2;
  localparam logic [2:0] CFG_TILE_HEIGHT = 3'd3;
  localparam logic [2:0] CFG_COLUMNS     = 3'd4;
  localparam logic [2:0] CFG_ROWS        = 3'd5;

  typedef enum logic [2:0] {
    OP_WRITE   = 3'd0,
    OP_POINT   = 3'd1,
    OP_RECT_Q  = 3'd2,
    OP_RECT_D  = 3'd3,
    OP_DESTROY = 3'd4
  } op_e;

  typedef enum logic [1:0] {
    CMD_NONE,
    CMD_WRITE,
    CMD_QUERY,
    CMD_DESTROY
  } cmd_kind_e;

  typedef enum logic [1:0] {
    FR_IDLE,
    FR_DIV_START,
    FR_DIV_WAIT,
    FR_PUSH
  } front_state_e;

  typedef enum logic [2:0] {
    BK_CLEAR,
    BK_IDLE,
    BK_SCAN,
    BK_DRAIN,
    BK_DONE
  } back_state_e;

  typedef struct packed {
    cmd_kind_e          kind;
    logic               hit;
    logic [1:0]         code;
    logic [COORD_W-1:0] x0;
    logic [COORD_W-1:0] x1;
    logic [COORD_W-1:0] y0;
    logic [COORD_W-1:0] y1;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

  typedef struct packed {
    logic signed [23:0] origin_x;
    logic signed [23:0] origin_y;
    logic [15:0]        tile_w;
    logic [15:0]        tile_h;
    logic [7:0]         cols;
    logic [7:0]         rows;
  } cfg_t;

endpackage

// ----- rtl/core/tile_collision_mask_engine_core.sv -----
// ----------------------------------------------------------------------------
// tile_collision_mask_engine_core
// Grid of 2-bit collision codes with tile writes, point/rectangle queries and
// destroys on signed 16.8 fixed-point coordinates.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries one operation per
//   transaction; every transaction yields exactly one result transaction
//   (out_valid_o / out_stall_i) with hit_o, 0 for writes and destroys.
//   Configuration registers are written through cfg_valid_i / cfg_ready_o (always ready) with
//   cfg_index_i and cfg_data_i; the user must write them only while idle (not enforced).
// Processing:
//   Each coordinate division runs in the shared bit-serial divider.
//   Point query: 2 divisions and one tile read; no tile read off grid.
//   Rectangle ops: 4 divisions, then one tile per cycle over the
//   clamped range, set by the single store read port; no walk for an empty range
//   or an outside hit. The command queue lets the divider work on the next
//   item while the back end walks tiles.
// Reset:
//   Registers take their reset values; the store is then cleared one entry a
//   cycle, all MAX_COLUMNS*MAX_ROWS entries (16384 by default), with in_stall_o
//   high meanwhile.
// Stall:
//   A held result sits in the output register; the back end then waits, the
//   queue fills and the front waits in FR_PUSH, keeping in_stall_o high.
// ----------------------------------------------------------------------------
module tile_collision_mask_engine_core #(
  parameter int unsigned MAX_COLUMNS = tcme_pkg::DEF_MAX_COLUMNS,
  parameter int unsigned MAX_ROWS    = tcme_pkg::DEF_MAX_ROWS
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [2:0]         operation_i,
  input  logic signed [23:0] pos_x_i,
  input  logic signed [23:0] pos_y_i,
  input  logic [22:0]        rect_width_i,
  input  logic [22:0]        rect_height_i,
  input  logic [6:0]         tile_col_i,
  input  logic [6:0]         tile_row_i,
  input  logic [1:0]         collision_code_i,
  input  logic               outside_solid_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic               hit_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [2:0]         cfg_index_i,
  input  logic [23:0]        cfg_data_i
);
  import tcme_pkg::*;

  cfg_t          cfg_q;
  cmd_t          push_cmd, head_cmd;
  queue_status_t q_status;
  logic          push, pop, clear_busy;

  assign cfg_ready_o = 1'b1;

  // configuration register file; unknown indexes are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.origin_x <= '0;
      cfg_q.origin_y <= '0;
      cfg_q.tile_w   <= 16'd256;
      cfg_q.tile_h   <= 16'd256;
      cfg_q.cols     <= 8'd128;
      cfg_q.rows     <= 8'd128;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_ORIGIN_X:    cfg_q.origin_x <= cfg_data_i;
        CFG_ORIGIN_Y:    cfg_q.origin_y <= cfg_data_i;
        CFG_TILE_WIDTH:  cfg_q.tile_w   <= cfg_data_i[15:0];
        CFG_TILE_HEIGHT: cfg_q.tile_h   <= cfg_data_i[15:0];
        CFG_COLUMNS:     cfg_q.cols     <= cfg_data_i[7:0];
        CFG_ROWS:        cfg_q.rows     <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  // front: accept, tile mapping, classification
  tcme_front #(
    .MAX_COLUMNS (MAX_COLUMNS),
    .MAX_ROWS    (MAX_ROWS)
  ) u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_i            (cfg_q),
    .clear_busy_i     (clear_busy),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .operation_i      (operation_i),
    .pos_x_i          (pos_x_i),
    .pos_y_i          (pos_y_i),
    .rect_width_i     (rect_width_i),
    .rect_height_i    (rect_height_i),
    .tile_col_i       (tile_col_i),
    .tile_row_i       (tile_row_i),
    .collision_code_i (collision_code_i),
    .outside_solid_i  (outside_solid_i),
    .push_o           (push),
    .cmd_o            (push_cmd),
    .q_status_i       (q_status)
  );

  tcme_queue u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .cmd_i    (push_cmd),
    .pop_i    (pop),
    .cmd_o    (head_cmd),
    .status_o (q_status)
  );

  // back: store access and result register
  tcme_back #(
    .MAX_COLUMNS (MAX_COLUMNS),
    .MAX_ROWS    (MAX_ROWS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (head_cmd),
    .q_status_i   (q_status),
    .pop_o        (pop),
    .clear_busy_o (clear_busy),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .hit_o        (hit_o)
  );

endmodule

// ----- rtl/core/tcme_div.sv -----
// ----------------------------------------------------------------------------
// tcme_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module tcme_div (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic [tcme_pkg::DIV_NUM_W-1:0] num_i,
  input  logic [tcme_pkg::DIV_DEN_W-1:0] den_i,
  output logic                           done_o,
  output logic [tcme_pkg::DIV_NUM_W-1:0] quo_o
);
  import tcme_pkg::*;

  localparam int unsigned CNT_W = $clog2(DIV_NUM_W);

  logic                 busy_q, done_q;
  logic [CNT_W-1:0]     cnt_q;
  logic [DIV_DEN_W-1:0] rem_q, den_q;
  logic [DIV_NUM_W-1:0] quo_q;
  logic [DIV_DEN_W:0]   shifted, diff;
  logic                 ge;

  assign shifted = {rem_q, quo_q[DIV_NUM_W-1]};
  assign ge      = shifted >= {1'b0, den_q};
  assign diff    = shifted - {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CNT_W'(DIV_NUM_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= num_i;
      den_q <= den_i;
    end else if (busy_q) begin
      rem_q <= ge ? diff[DIV_DEN_W-1:0] : shifted[DIV_DEN_W-1:0];
      quo_q <= {quo_q[DIV_NUM_W-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

// ----- rtl/core/tcme_front.sv -----
// ----------------------------------------------------------------------------
// tcme_front
// Accepts items, maps coordinates to tiles and resolves each item to a command.
// ----------------------------------------------------------------------------
module tcme_front #(
  parameter int unsigned MAX_COLUMNS = tcme_pkg::DEF_MAX_COLUMNS,
  parameter int unsigned MAX_ROWS    = tcme_pkg::DEF_MAX_ROWS
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  tcme_pkg::cfg_t          cfg_i,
  input  logic                    clear_busy_i,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic [2:0]              operation_i,
  input  logic signed [23:0]      pos_x_i,
  input  logic signed [23:0]      pos_y_i,
  input  logic [22:0]             rect_width_i,
  input  logic [22:0]             rect_height_i,
  input  logic [6:0]              tile_col_i,
  input  logic [6:0]              tile_row_i,
  input  logic [1:0]              collision_code_i,
  input  logic                    outside_solid_i,
  output logic                    push_o,
  output tcme_pkg::cmd_t          cmd_o,
  input  tcme_pkg::queue_status_t q_status_i
);
  import tcme_pkg::*;

  front_state_e state_q, state_d;
  logic         accept;

  op_e                op_q;
  logic signed [23:0] px_q, py_q;
  logic [22:0]        rw_q, rh_q;
  logic [6:0]         col_q, row_q;
  logic [1:0]         code_q;
  logic               outside_q;
  logic [1:0]         step_q;
  logic               neg_q;
  logic signed [TILE_W-1:0] t_q [4];

  logic signed [24:0]        p_sel;
  logic signed [23:0]        org_sel;
  logic [15:0]               size_sel;
  logic signed [DIV_NUM_W-1:0] d;
  logic [DIV_NUM_W-1:0]      mag;
  logic [DIV_DEN_W-1:0]      den;
  logic                      div_start, div_done;
  logic [DIV_NUM_W-1:0]      quo;
  logic signed [TILE_W-1:0]  t_new;
  logic [1:0]                last_step;

  logic signed [TILE_W-1:0] w_s, h_s, colx, rowx, cx0, cx1, cy0, cy1;
  logic                     off;

  assign accept     = in_valid_i && !in_stall_o;
  assign in_stall_o = !(state_q == FR_IDLE && !clear_busy_i);
  assign last_step  = (op_q == OP_POINT) ? 2'd1 : 2'd3;

  // numerator and divisor for the current coordinate
  always_comb begin
    case (step_q)
      2'd0:    begin p_sel = 25'(px_q); org_sel = cfg_i.origin_x; size_sel = cfg_i.tile_w; end
      2'd1:    begin p_sel = 25'(py_q); org_sel = cfg_i.origin_y; size_sel = cfg_i.tile_h; end
      2'd2:    begin
        p_sel = 25'(px_q) + $signed({2'b00, rw_q});
        org_sel = cfg_i.origin_x; size_sel = cfg_i.tile_w;
      end
      default: begin
        p_sel = 25'(py_q) + $signed({2'b00, rh_q});
        org_sel = cfg_i.origin_y; size_sel = cfg_i.tile_h;
      end
    endcase
  end

  assign d         = DIV_NUM_W'(p_sel) - DIV_NUM_W'(org_sel);
  assign mag       = d[DIV_NUM_W-1] ? DIV_NUM_W'(-d) : DIV_NUM_W'(d);
  assign den       = (size_sel == '0) ? DIV_DEN_W'(1) : size_sel;
  assign div_start = (state_q == FR_DIV_START);
  // floor-ish mapping: negative offsets give -q-1
  assign t_new     = neg_q ? ~$signed({1'b0, quo}) : $signed({1'b0, quo});

  tcme_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (mag),
    .den_i   (den),
    .done_o  (div_done),
    .quo_o   (quo)
  );

  always_comb begin
    state_d = state_q;
    case (state_q)
      FR_IDLE: begin
        if (accept) begin
          if (op_e'(operation_i) inside {OP_POINT, OP_RECT_Q, OP_RECT_D}) begin
            state_d = FR_DIV_START;
          end else begin
            state_d = FR_PUSH;
          end
        end
      end
      FR_DIV_START: state_d = FR_DIV_WAIT;
      FR_DIV_WAIT: begin
        if (div_done) begin
          state_d = (step_q == last_step) ? FR_PUSH : FR_DIV_START;
        end
      end
      FR_PUSH: begin
        if (!q_status_i.full) begin
          state_d = FR_IDLE;
        end
      end
      default: state_d = FR_IDLE;
    endcase
  end

  always_comb begin
    push_o = (state_q == FR_PUSH) && !q_status_i.full;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= FR_IDLE;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      if (accept) begin
        step_q <= '0;
      end else if (state_q == FR_DIV_WAIT && div_done) begin
        step_q <= step_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q      <= op_e'(operation_i);
      px_q      <= pos_x_i;
      py_q      <= pos_y_i;
      rw_q      <= rect_width_i;
      rh_q      <= rect_height_i;
      col_q     <= tile_col_i;
      row_q     <= tile_row_i;
      code_q    <= collision_code_i;
      outside_q <= outside_solid_i;
    end
    if (div_start) begin
      neg_q <= d[DIV_NUM_W-1];
    end
    if (state_q == FR_DIV_WAIT && div_done) begin
      t_q[step_q] <= t_new;
    end
  end

  // grid size clamped to 1..MAX
  always_comb begin
    if (cfg_i.cols == '0) begin
      w_s = TILE_W'(1);
    end else if (TILE_W'(cfg_i.cols) > TILE_W'(MAX_COLUMNS)) begin
      w_s = TILE_W'(MAX_COLUMNS);
    end else begin
      w_s = TILE_W'(cfg_i.cols);
    end
    if (cfg_i.rows == '0) begin
      h_s = TILE_W'(1);
    end else if (TILE_W'(cfg_i.rows) > TILE_W'(MAX_ROWS)) begin
      h_s = TILE_W'(MAX_ROWS);
    end else begin
      h_s = TILE_W'(cfg_i.rows);
    end
  end

  assign colx = TILE_W'(col_q);
  assign rowx = TILE_W'(row_q);
  assign cx0  = (t_q[0] < 0) ? '0 : t_q[0];
  assign cy0  = (t_q[1] < 0) ? '0 : t_q[1];
  assign cx1  = (t_q[2] >= w_s) ? w_s - 1 : t_q[2];
  assign cy1  = (t_q[3] >= h_s) ? h_s - 1 : t_q[3];
  assign off  = (t_q[0] < 0) || (t_q[2] >= w_s) || (t_q[1] < 0) || (t_q[3] >= h_s);

  always_comb begin
    cmd_o      = '0;
    cmd_o.kind = CMD_NONE;
    case (op_q)
      OP_WRITE, OP_DESTROY: begin
        if (colx < w_s && rowx < h_s) begin
          cmd_o.kind = (op_q == OP_WRITE) ? CMD_WRITE : CMD_DESTROY;
          cmd_o.code = code_q;
          cmd_o.x0   = COORD_W'(col_q);
          cmd_o.x1   = COORD_W'(col_q);
          cmd_o.y0   = COORD_W'(row_q);
          cmd_o.y1   = COORD_W'(row_q);
        end
      end
      OP_POINT: begin
        if (t_q[0] < 0 || t_q[0] >= w_s || t_q[1] < 0 || t_q[1] >= h_s) begin
          cmd_o.hit = outside_q;
        end else begin
          cmd_o.kind = CMD_QUERY;
          cmd_o.x0   = t_q[0][COORD_W-1:0];
          cmd_o.x1   = t_q[0][COORD_W-1:0];
          cmd_o.y0   = t_q[1][COORD_W-1:0];
          cmd_o.y1   = t_q[1][COORD_W-1:0];
        end
      end
      OP_RECT_Q, OP_RECT_D: begin
        if (op_q == OP_RECT_Q && outside_q && off) begin
          cmd_o.hit = 1'b1;
        end else if (!(t_q[0] >= w_s || t_q[2] < 0 || t_q[1] >= h_s || t_q[3] < 0)) begin
          cmd_o.kind = (op_q == OP_RECT_Q) ? CMD_QUERY : CMD_DESTROY;
          cmd_o.x0   = cx0[COORD_W-1:0];
          cmd_o.x1   = cx1[COORD_W-1:0];
          cmd_o.y0   = cy0[COORD_W-1:0];
          cmd_o.y1   = cy1[COORD_W-1:0];
        end
      end
      default: cmd_o.kind = CMD_NONE;
    endcase
  end

  a_done_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> state_q == FR_DIV_WAIT)
    else $error("divider finished outside the wait state");

endmodule

// ----- rtl/core/tcme_queue.sv -----
// ----------------------------------------------------------------------------
// tcme_queue
// Short command FIFO between the front and the back.
// ----------------------------------------------------------------------------
module tcme_queue (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    push_i,
  input  tcme_pkg::cmd_t          cmd_i,
  input  logic                    pop_i,
  output tcme_pkg::cmd_t          cmd_o,
  output tcme_pkg::queue_status_t status_o
);
  import tcme_pkg::*;

  localparam int unsigned PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);

  cmd_t          mem_q [QUEUE_DEPTH];
  logic [PW-1:0] wr_q, rd_q;
  logic [CW-1:0] cnt_q;

  function automatic logic [PW-1:0] nxt(input logic [PW-1:0] p);
    nxt = (p == PW'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= nxt(wr_q);
      if (pop_i)  rd_q <= nxt(rd_q);
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= cmd_i;
  end

  assign cmd_o          = mem_q[rd_q];
  assign status_o.full  = (cnt_q == CW'(QUEUE_DEPTH));
  assign status_o.empty = (cnt_q == '0);

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !status_o.full)
    else $error("push into a full queue");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !status_o.empty)
    else $error("pop from an empty queue");

endmodule

// ----- rtl/core/tcme_back.sv -----
// ----------------------------------------------------------------------------
// tcme_back
// Owns the collision store: clearing pass, writes and tile walks.
// ----------------------------------------------------------------------------
module tcme_back #(
  parameter int unsigned MAX_COLUMNS = tcme_pkg::DEF_MAX_COLUMNS,
  parameter int unsigned MAX_ROWS    = tcme_pkg::DEF_MAX_ROWS
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  tcme_pkg::cmd_t          cmd_i,
  input  tcme_pkg::queue_status_t q_status_i,
  output logic                    pop_o,
  output logic                    clear_busy_o,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic                    hit_o
);
  import tcme_pkg::*;

  localparam int unsigned DEPTH = MAX_COLUMNS * MAX_ROWS;
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  back_state_e state_q, state_d;

  logic [1:0]         mem [DEPTH];
  logic [1:0]         rd_data_q;
  logic [AW-1:0]      clr_q, rd_addr, wr_addr, p1_addr_q;
  logic [1:0]         wr_data;
  logic               we;
  cmd_t               cmd_q;
  logic [COORD_W-1:0] x_q, y_q;
  logic               p1_vld_q, p1_last_q;
  logic               hit_q, out_valid_q, out_hit_q;
  logic               at_end, clr_last, out_load;

  function automatic logic [AW-1:0] addr_of(input logic [COORD_W-1:0] x,
                                            input logic [COORD_W-1:0] y);
    addr_of = AW'(y) * AW'(MAX_COLUMNS) + AW'(x);
  endfunction

  assign at_end   = (x_q == cmd_q.x1) && (y_q == cmd_q.y1);
  assign clr_last = (clr_q == AW'(DEPTH - 1));
  assign rd_addr  = addr_of(x_q, y_q);
  assign out_load = (state_q == BK_DONE) && (!out_valid_q || !out_stall_i);

  always_comb begin
    state_d = state_q;
    case (state_q)
      BK_CLEAR: if (clr_last) state_d = BK_IDLE;
      BK_IDLE: begin
        if (!q_status_i.empty) begin
          state_d = (cmd_i.kind == CMD_QUERY || cmd_i.kind == CMD_DESTROY) ?
                    BK_SCAN : BK_DONE;
        end
      end
      BK_SCAN:  if (at_end) state_d = BK_DRAIN;
      BK_DRAIN: state_d = BK_DONE;
      BK_DONE:  if (out_load) state_d = BK_IDLE;
      default:  state_d = BK_CLEAR;
    endcase
  end

  always_comb begin
    pop_o        = (state_q == BK_IDLE) && !q_status_i.empty;
    clear_busy_o = (state_q == BK_CLEAR);
    we           = 1'b0;
    wr_addr      = clr_q;
    wr_data      = CODE_EMPTY;
    if (state_q == BK_CLEAR) begin
      we = 1'b1;
    end else if (pop_o && cmd_i.kind == CMD_WRITE) begin
      we      = 1'b1;
      wr_addr = addr_of(cmd_i.x0, cmd_i.y0);
      wr_data = cmd_i.code;
    end else if (p1_vld_q && cmd_q.kind == CMD_DESTROY && rd_data_q != CODE_HARD) begin
      we      = 1'b1;
      wr_addr = p1_addr_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) mem[wr_addr] <= wr_data;
  end

  always_ff @(posedge clk_i) begin
    if (state_q == BK_SCAN) rd_data_q <= mem[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_CLEAR;
      clr_q       <= '0;
      p1_vld_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      p1_vld_q <= (state_q == BK_SCAN);
      if (state_q == BK_CLEAR) clr_q <= clr_q + 1'b1;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      cmd_q <= cmd_i;
      x_q   <= cmd_i.x0;
      y_q   <= cmd_i.y0;
      hit_q <= cmd_i.hit;
    end else begin
      if (state_q == BK_SCAN) begin
        if (x_q == cmd_q.x1) begin
          x_q <= cmd_q.x0;
          y_q <= y_q + 1'b1;
        end else begin
          x_q <= x_q + 1'b1;
        end
      end
      if (p1_vld_q && cmd_q.kind == CMD_QUERY && rd_data_q != CODE_EMPTY) begin
        hit_q <= 1'b1;
      end
    end
    p1_addr_q <= rd_addr;
    p1_last_q <= at_end;
    if (out_load) out_hit_q <= hit_q;
  end

  assign out_valid_o = out_valid_q;
  assign hit_o       = out_hit_q;

  a_p1_from_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    p1_vld_q |-> $past(state_q == BK_SCAN))
    else $error("read stage valid without a scan cycle");

  a_drain_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == BK_DRAIN |-> p1_vld_q && p1_last_q)
    else $error("drain without the last tile in flight");

endmodule
